FILE: src/color_code_glyph_renderer_core_assert.svh
// assertion macros for the glyph renderer core
// no dependencies; included by color_code_glyph_renderer_core, the module that carries assertions
`ifndef COLOR_CODE_GLYPH_RENDERER_CORE_ASSERT_SVH
`define COLOR_CODE_GLYPH_RENDERER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// check a property on each rising edge, held off while reset is low
`define CCGR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on each rising edge, reset included
`define CCGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCGR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/ccgr_pkg.sv
// shared types and constants of the glyph renderer core
// no dependencies; used by ccgr_font_ram and color_code_glyph_renderer_core
package ccgr_pkg;

    // font store geometry: 256 glyphs of 8 rows
    localparam int unsigned FONT_ADDR_BITS = 11;
    localparam int unsigned FONT_DEPTH     = 256 * 8;
    localparam int unsigned ROW_BITS       = 3;

    // input word layout
    localparam int unsigned IN_TDATA_BITS = 32;
    localparam int unsigned IN_TUSER_BITS = 2;
    localparam int unsigned ADDR_LSB      = 0;
    localparam int unsigned BYTE_LSB      = 11;
    localparam int unsigned CHAR_LSB      = 19;
    localparam int unsigned USER_KIND     = 0;
    localparam int unsigned USER_START    = 1;

    // item kinds
    localparam logic KIND_FONT_WRITE = 1'b0;
    localparam logic KIND_CHAR       = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_COLOR    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKGROUND_COLOR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGHLIGHT_COLOR  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEXT_COLOR       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X         = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y         = 3'd5;

    // character codes of the escape syntax
    localparam logic [7:0] CHAR_BAR    = 8'h7C;
    localparam logic [7:0] CHAR_H_UP   = 8'h48;
    localparam logic [7:0] CHAR_H_LOW  = 8'h68;
    localparam logic [7:0] CHAR_T_UP   = 8'h54;
    localparam logic [7:0] CHAR_T_LOW  = 8'h74;
    localparam logic [7:0] CHAR_U_UP   = 8'h55;
    localparam logic [7:0] CHAR_U_LOW  = 8'h75;

    localparam int unsigned COLUMN_BITS = 9;

    typedef enum logic [1:0] {
        ESC_NORMAL  = 2'd0,
        ESC_BAR     = 2'd1,
        ESC_SKIP    = 2'd2,
        ESC_LITERAL = 2'd3
    } t_esc_state;

    typedef struct packed {
        logic                      en;
        logic [FONT_ADDR_BITS-1:0] addr;
        logic [7:0]                data;
    } t_font_wr;

    typedef struct packed {
        logic                      en;
        logic [FONT_ADDR_BITS-1:0] addr;
    } t_font_rd;

endpackage

FILE: src/color_code_glyph_renderer_core.sv
// top level of the 8x8 glyph renderer with inline color codes
// depends on ccgr_pkg, ccgr_font_ram and color_code_glyph_renderer_core_assert.svh
//
// usage
//   input stream (s_axis): one word per item. tuser[0] is the kind: 0 loads one
//   font byte, 1 carries a text character. font words give no output.
//   a character is run through the escape decoder (|H |T |U color
//   codes, || for a literal bar); a drawn character gives eight output words,
//   one glyph row each, top row first, tlast on the eighth row.
//   output stream (m_axis): pixel x, pixel y and eight pixel colors per word.
//   config port: plain write, index per register list; the user keeps it
//   written only while idle; the block itself does not enforce this.
//   flow: an accepted character is latched into the row sequencer, which reads
//   the font memory one row per cycle while the output is not stalled; each
//   row passes through stage 1 into the output register, one word per cycle.
//   the next item is taken in the cycle the eighth row is issued; undrawn
//   characters and font writes are taken while the sequencer is free.
//   stall: when m_axis_tready is low the output register holds, the sequencer
//   and the memory read stop, and input is held off once the current glyph
//   occupies the sequencer.
//   reset: synchronous, active low; clears escape state, color, column, config
//   registers and all valid flags. font memory contents are not cleared.
module color_code_glyph_renderer_core #(
    parameter int COLOR_BITS = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: font_addr[10:0], font_byte[18:11], char_code[26:19], zero fill
    input  logic [ccgr_pkg::IN_TDATA_BITS-1:0]    i_s_axis_tdata,
    // tuser: kind[0], string_start[1]
    input  logic [ccgr_pkg::IN_TUSER_BITS-1:0]    i_s_axis_tuser,
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata: pixel_x, pixel_y, color_0 .. color_7, zero fill to whole bytes
    output logic [((2*COORD_BITS + 8*COLOR_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [ccgr_pkg::CFG_IDX_BITS-1:0]     i_cfg_addr,
    input  logic [(COLOR_BITS > COORD_BITS ? COLOR_BITS : COORD_BITS)-1:0] i_cfg_wdata
);

`include "color_code_glyph_renderer_core_assert.svh"

    localparam int XW = (COORD_BITS > 12) ? COORD_BITS : 12;

    // configuration registers
    logic [COLOR_BITS-1:0] r_default, r_background, r_highlight, r_text;
    logic [COORD_BITS-1:0] r_origin_x, r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default    <= '0;
            r_background <= '0;
            r_highlight  <= '0;
            r_text       <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ccgr_pkg::CFG_DEFAULT_COLOR:    r_default    <= i_cfg_wdata[COLOR_BITS-1:0];
                ccgr_pkg::CFG_BACKGROUND_COLOR: r_background <= i_cfg_wdata[COLOR_BITS-1:0];
                ccgr_pkg::CFG_HIGHLIGHT_COLOR:  r_highlight  <= i_cfg_wdata[COLOR_BITS-1:0];
                ccgr_pkg::CFG_TEXT_COLOR:       r_text       <= i_cfg_wdata[COLOR_BITS-1:0];
                ccgr_pkg::CFG_ORIGIN_X:         r_origin_x   <= i_cfg_wdata[COORD_BITS-1:0];
                ccgr_pkg::CFG_ORIGIN_Y:         r_origin_y   <= i_cfg_wdata[COORD_BITS-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // input word fields
    logic                                in_kind, in_start;
    logic [ccgr_pkg::FONT_ADDR_BITS-1:0] in_font_addr;
    logic [7:0]                          in_font_byte, in_char;

    assign in_kind      = i_s_axis_tuser[ccgr_pkg::USER_KIND];
    assign in_start     = i_s_axis_tuser[ccgr_pkg::USER_START];
    assign in_font_addr = i_s_axis_tdata[ccgr_pkg::ADDR_LSB +: ccgr_pkg::FONT_ADDR_BITS];
    assign in_font_byte = i_s_axis_tdata[ccgr_pkg::BYTE_LSB +: 8];
    assign in_char      = i_s_axis_tdata[ccgr_pkg::CHAR_LSB +: 8];

    // pipeline control
    logic                          adv;        // stage 1 may move into the output register
    logic                          issue;      // sequencer reads one glyph row
    logic                          in_accept, char_accept, draw_start;
    logic                          r_gen_busy;
    logic [ccgr_pkg::ROW_BITS-1:0] r_row;
    logic                          r_out_valid;

    assign adv         = !r_out_valid || i_m_axis_tready;
    assign issue       = r_gen_busy && adv;
    assign o_s_axis_tready = !r_gen_busy || ((r_row == '1) && adv);
    assign in_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign char_accept = in_accept && (in_kind == ccgr_pkg::KIND_CHAR);

    // escape decoder, column and current color
    ccgr_pkg::t_esc_state             r_esc, n_esc, esc_in;
    logic [COLOR_BITS-1:0]            r_color, n_color, color_in;
    logic [ccgr_pkg::COLUMN_BITS-1:0] r_col, n_col, col_in;
    logic                             draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ccgr_pkg::ESC_NORMAL;
            r_color <= '0;
            r_col   <= '0;
        end else begin
            r_esc   <= n_esc;
            r_color <= n_color;
            r_col   <= n_col;
        end
    end

    always_comb begin
        // string start clears column and escape and sets the default color before this character
        esc_in   = in_start ? ccgr_pkg::ESC_NORMAL : r_esc;
        color_in = in_start ? r_default : r_color;
        col_in   = in_start ? '0 : r_col;
        n_esc    = r_esc;
        n_color  = r_color;
        n_col    = r_col;
        draw     = 1'b0;
        if (char_accept) begin
            n_esc   = esc_in;
            n_color = color_in;
            n_col   = col_in;
            unique case (esc_in)
                ccgr_pkg::ESC_NORMAL: begin
                    if (in_char == ccgr_pkg::CHAR_BAR) begin
                        n_esc = ccgr_pkg::ESC_BAR;
                    end else begin
                        draw = 1'b1;
                    end
                end
                ccgr_pkg::ESC_BAR: begin
                    if (in_char == ccgr_pkg::CHAR_BAR) begin
                        n_esc = ccgr_pkg::ESC_NORMAL;
                        draw  = 1'b1;
                    end else begin
                        // selector; an unknown one keeps the color
                        priority if (in_char == ccgr_pkg::CHAR_H_UP ||
                                     in_char == ccgr_pkg::CHAR_H_LOW) begin
                            n_color = r_highlight;
                        end else if (in_char == ccgr_pkg::CHAR_T_UP ||
                                     in_char == ccgr_pkg::CHAR_T_LOW) begin
                            n_color = r_text;
                        end else if (in_char == ccgr_pkg::CHAR_U_UP ||
                                     in_char == ccgr_pkg::CHAR_U_LOW) begin
                            n_color = r_default;
                        end else begin
                            n_color = color_in;
                        end
                        n_esc = ccgr_pkg::ESC_SKIP;
                    end
                end
                ccgr_pkg::ESC_SKIP: begin
                    n_esc = ccgr_pkg::ESC_LITERAL;
                end
                ccgr_pkg::ESC_LITERAL: begin
                    n_esc = ccgr_pkg::ESC_NORMAL;
                    draw  = 1'b1;
                end
                default: begin
                    n_esc = ccgr_pkg::ESC_NORMAL;
                end
            endcase
            if (draw) begin
                n_col = col_in + 1'b1;  // wraps at 512
            end
        end
    end

    assign draw_start = draw;

    // row sequencer: one glyph row read per cycle while the output is not stalled
    logic [7:0]            r_gen_code;
    logic [COLOR_BITS-1:0] r_gen_fg;
    logic [COORD_BITS-1:0] r_gen_x;
    logic [XW-1:0]         x_sum;

    assign x_sum = XW'(r_origin_x) + XW'({col_in, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_busy <= 1'b0;
            r_row      <= '0;
        end else if (draw_start) begin
            r_gen_busy <= 1'b1;
            r_row      <= '0;
        end else if (issue) begin
            if (r_row == '1) begin
                r_gen_busy <= 1'b0;
            end
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw_start) begin
            r_gen_code <= in_char;
            r_gen_fg   <= color_in;
            r_gen_x    <= x_sum[COORD_BITS-1:0];
        end
    end

    // font memory
    ccgr_pkg::t_font_wr font_wr;
    ccgr_pkg::t_font_rd font_rd;
    logic [7:0]         font_rdata;

    assign font_wr.en   = in_accept && (in_kind == ccgr_pkg::KIND_FONT_WRITE);
    assign font_wr.addr = in_font_addr;
    assign font_wr.data = in_font_byte;
    assign font_rd.en   = issue;
    assign font_rd.addr = {r_gen_code, r_row};

    ccgr_font_ram u_font_ram (
        .i_clk   (i_clk),
        .i_wr    (font_wr),
        .i_rd    (font_rd),
        .o_rdata (font_rdata)
    );

    // stage 1: row data in flight through the memory read
    logic                  r_s1_valid, r_s1_last;
    logic [COLOR_BITS-1:0] r_s1_fg;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_fg   <= r_gen_fg;
            r_s1_x    <= r_gen_x;
            r_s1_y    <= r_origin_y + {{(COORD_BITS - ccgr_pkg::ROW_BITS){1'b0}}, r_row};
            r_s1_last <= (r_row == '1);
        end
    end

    // output register
    logic                  r_out_last;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [COLOR_BITS-1:0] r_out_color [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_x    <= r_s1_x;
            r_out_y    <= r_s1_y;
            r_out_last <= r_s1_last;
            for (int p = 0; p < 8; p++) begin
                // pixel 0 is the leftmost, taken from bit 7
                r_out_color[p] <= font_rdata[7 - p] ? r_s1_fg : r_background;
            end
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[COORD_BITS-1:0]            = r_out_x;
        o_m_axis_tdata[COORD_BITS +: COORD_BITS]  = r_out_y;
        for (int p = 0; p < 8; p++) begin
            o_m_axis_tdata[2*COORD_BITS + p*COLOR_BITS +: COLOR_BITS] = r_out_color[p];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;

    // checks
    `CCGR_ASSERT(a_no_input_mid_glyph, i_clk, i_rst_n,
        (in_accept && r_gen_busy) |-> (r_row == '1 && issue),
        "input accepted while a glyph still occupies the row sequencer")
    `CCGR_ASSERT(a_last_row_marked, i_clk, i_rst_n,
        (issue && r_row == '1) |=> (r_s1_valid && r_s1_last),
        "eighth row read without the last-row mark")
    `CCGR_ASSERT(a_stage1_holds, i_clk, i_rst_n,
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1_y)),
        "row in flight lost during an output stall")
    `CCGR_ASSERT(a_no_read_on_stall, i_clk, i_rst_n,
        !adv |-> !font_rd.en,
        "font read issued while the output register is stalled")

endmodule

FILE: src/ccgr_font_ram.sv
// font store: 2048 x 8 synchronous memory, one write and one read port
// depends on ccgr_pkg; read data is registered, old data on a same-address write
module ccgr_font_ram (
    input  logic                i_clk,
    input  ccgr_pkg::t_font_wr  i_wr,
    input  ccgr_pkg::t_font_rd  i_rd,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [ccgr_pkg::FONT_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
